/* rtl/ftrm_pkg.sv */
// package: shared constants for the fan tachometer rpm meter
package ftrm_pkg;

    localparam int unsigned CNT_W    = 32;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned PPR_W    = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_W    = CNT_W + 16;
    localparam int unsigned DEN_W    = CNT_W + PPR_W;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 8'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [PPR_W-1:0] PPR_RESET    = 8'd2;
    localparam logic [15:0]      MS_PER_MIN   = 16'd60000;
    localparam logic [CNT_W-1:0] RPM_SAT      = 32'hFFFF_FFFF;

endpackage

/* rtl/ftrm_if.sv */
// interfaces: input item, result and configuration channels
interface ftrm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ftrm_pkg::CNT_W-1:0]    now_ms;

    modport source (output valid, kind, now_ms, input ready);
    modport sink   (input valid, kind, now_ms, output ready);
endinterface

interface ftrm_out_if;
    logic                          valid;
    logic                          ready;
    logic [ftrm_pkg::CNT_W-1:0]    rpm_value;
    logic [ftrm_pkg::CNT_W-1:0]    pulse_total;
    logic                          measured;

    modport source (output valid, rpm_value, pulse_total, measured, input ready);
    modport sink   (input valid, rpm_value, pulse_total, measured, output ready);
endinterface

interface ftrm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ftrm_pkg::CFG_IDX_W-1:0]    index;
    logic [ftrm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/fan_tach_rpm_meter.sv */
// fan tachometer rpm meter: edge counter and rpm from a restoring divider
// an edge word or an update below the window gives its result in the cycle after accept
// a measurement runs 1 multiply, 1 saturation check, 32 divide steps, 1 writeback
// a saturated rpm skips the 32-step radix-2 divider and goes from the check to the writeback
// throughput: 1 edge word per cycle while the result drains; none taken while measuring
// reset (rst_n async low): counters, snapshots and rpm clear, window 1000 ms, 2 pulses/rev
module fan_tach_rpm_meter (
    input  logic          clk,
    input  logic          rst_n,
    ftrm_in_if.sink       item,
    ftrm_out_if.source    result,
    ftrm_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_DONE
    } state_t;

    state_t                               state_reg;

    // configuration
    logic [ftrm_pkg::WIN_W-1:0]           window_reg;
    logic [ftrm_pkg::PPR_W-1:0]           ppr_reg;

    // measurement state
    logic [ftrm_pkg::CNT_W-1:0]           edge_count_reg;
    logic [ftrm_pkg::CNT_W-1:0]           edge_snap_reg;
    logic [ftrm_pkg::CNT_W-1:0]           time_snap_reg;
    logic [ftrm_pkg::CNT_W-1:0]           rpm_reg;

    // datapath of the divider
    logic [ftrm_pkg::CNT_W-1:0]           count_reg;
    logic [ftrm_pkg::CNT_W-1:0]           elapsed_reg;
    logic [ftrm_pkg::NUM_W-1:0]           num_reg;
    logic [ftrm_pkg::DEN_W-1:0]           den_reg;
    logic [ftrm_pkg::DEN_W-1:0]           rem_reg;
    logic [ftrm_pkg::CNT_W-1:0]           work_reg;   // low numerator bits in, quotient bits out
    logic [4:0]                           step_reg;

    // result word
    logic                                 out_valid_reg;
    logic [ftrm_pkg::CNT_W-1:0]           out_rpm_reg;
    logic [ftrm_pkg::CNT_W-1:0]           out_pulse_reg;
    logic                                 out_measured_reg;

    logic                                 out_free;
    logic                                 out_load;
    logic                                 in_fire;
    logic [ftrm_pkg::CNT_W-1:0]           elapsed_next;
    logic                                 window_hit;
    logic [ftrm_pkg::DEN_W:0]             trial;
    logic                                 trial_ge;
    logic [ftrm_pkg::DEN_W-1:0]           rem_next;
    logic [ftrm_pkg::DEN_W-1:0]           num_hi;

    // result slot can take a word when empty or being drained this cycle
    assign out_free = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire = item.valid && item.ready;

    // window test is modulo 2^32
    assign elapsed_next = item.now_ms - time_snap_reg;
    assign window_hit = elapsed_next >= ftrm_pkg::CNT_W'(window_reg);

    // a result word is loaded for edges, updates below the window and finished measurements
    assign out_load = ((state_reg == S_IDLE) && in_fire
                       && ((item.kind == ftrm_pkg::KIND_EDGE) || !window_hit))
                      || ((state_reg == S_DONE) && out_free);

    // one restoring divide step: shift in the next numerator bit, try the subtract
    assign trial = {rem_reg, work_reg[ftrm_pkg::CNT_W-1]};
    assign trial_ge = trial >= {1'b0, den_reg};
    assign rem_next = trial_ge ? ftrm_pkg::DEN_W'(trial - {1'b0, den_reg})
                               : trial[ftrm_pkg::DEN_W-1:0];

    // upper numerator bits; quotient overflows 32 bits iff den <= num_hi
    assign num_hi = ftrm_pkg::DEN_W'(num_reg[ftrm_pkg::NUM_W-1:ftrm_pkg::CNT_W]);

    assign cfg.ready = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.rpm_value   = out_rpm_reg;
    assign result.pulse_total = out_pulse_reg;
    assign result.measured    = out_measured_reg;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= ftrm_pkg::WINDOW_RESET;
            ppr_reg    <= ftrm_pkg::PPR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ftrm_pkg::CFG_WINDOW_MS:      window_reg <= cfg.data;
                ftrm_pkg::CFG_PULSES_PER_REV: ppr_reg    <= cfg.data[ftrm_pkg::PPR_W-1:0];
                default:                      ;
            endcase
        end
    end

    // sequencer, measurement state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            edge_snap_reg  <= '0;
            time_snap_reg  <= '0;
            rpm_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (item.kind == ftrm_pkg::KIND_EDGE)
                        begin
                            edge_count_reg   <= edge_count_reg + 1'b1;
                            out_rpm_reg      <= rpm_reg;
                            out_pulse_reg    <= edge_count_reg + 1'b1;
                            out_measured_reg <= 1'b0;
                        end
                        else if (window_hit)
                        begin
                            // take both snapshots now, rpm follows after the divide
                            count_reg     <= edge_count_reg - edge_snap_reg;
                            elapsed_reg   <= elapsed_next;
                            edge_snap_reg <= edge_count_reg;
                            time_snap_reg <= item.now_ms;
                            state_reg     <= S_MUL;
                        end
                        else
                        begin
                            out_rpm_reg      <= rpm_reg;
                            out_pulse_reg    <= edge_count_reg;
                            out_measured_reg <= 1'b0;
                        end
                    end
                end
                S_MUL:
                begin
                    num_reg   <= ftrm_pkg::NUM_W'(count_reg) * ftrm_pkg::NUM_W'(ftrm_pkg::MS_PER_MIN);
                    den_reg   <= ftrm_pkg::DEN_W'(ppr_reg) * ftrm_pkg::DEN_W'(elapsed_reg);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    // zero divisor also lands here and saturates
                    if (den_reg <= num_hi)
                    begin
                        work_reg  <= ftrm_pkg::RPM_SAT;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rem_reg   <= num_hi;
                        work_reg  <= num_reg[ftrm_pkg::CNT_W-1:0];
                        step_reg  <= 5'(ftrm_pkg::CNT_W - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rem_next;
                    work_reg <= {work_reg[ftrm_pkg::CNT_W-2:0], trial_ge};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        rpm_reg          <= work_reg;
                        out_rpm_reg      <= work_reg;
                        out_pulse_reg    <= edge_count_reg;
                        out_measured_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an edge word always gives an unmeasured result on the next cycle
    a_edge_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && item.kind == ftrm_pkg::KIND_EDGE) |=> (result.valid && !result.measured))
        else $error("edge word did not give an unmeasured result");

    // a zero or too small divisor must be caught before the divide loop
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg > rem_reg))
        else $error("divider running with remainder not below divisor");

    // the word on offer always shows the stored rpm
    a_rpm_match: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.rpm_value == rpm_reg))
        else $error("result rpm differs from stored rpm");

    // no new word is taken while a measurement is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !item.ready)
        else $error("input ready during measurement");

endmodule
